// File: rtl/wavhp_pkg.sv
package wavhp_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned WordW  = 32;
   localparam int unsigned HalfW  = 16;
   localparam int unsigned CountW = 33;

   localparam logic [WordW-1:0] TagRiff = 32'h5249_4646;
   localparam logic [WordW-1:0] TagWave = 32'h5741_5645;
   localparam logic [WordW-1:0] TagFmt  = 32'h666D_7420;
   localparam logic [WordW-1:0] TagData = 32'h6461_7461;

   localparam logic [HalfW-1:0] FmtPcm      = 16'd1;
   localparam logic [HalfW-1:0] FmtChannels = 16'd2;
   localparam logic [HalfW-1:0] FmtBits     = 16'd16;
   localparam logic [WordW-1:0] FmtMinSize  = 32'd16;

   localparam logic StatusAccept = 1'b0;
   localparam logic StatusReject = 1'b1;

   typedef enum logic [4:0] {
      PH_HEAD  = 5'b00001,
      PH_CHUNK = 5'b00010,
      PH_FMT   = 5'b00100,
      PH_SKIP  = 5'b01000,
      PH_DONE  = 5'b10000
   } phase_type;

endpackage

// File: rtl/wav_header_parser_unit.sv
// channel  direction  handshake               payload
// req      in         req_valid / req_stall   req_byte_value, req_first_byte, req_last_byte
// rsp      out        rsp_valid / rsp_stall   rsp_status, rsp_sample_rate, rsp_data_bytes
//
// one byte is taken per cycle while req_stall is low; its verdict, if any, appears in the next cycle
// the parse state is updated by one compare, shift and count step per byte
// reset is synchronous and returns the parser to the start of a file
// req_stall rises only while a verdict waits in the output register and rsp_stall is high
module wav_header_parser_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [wavhp_pkg::ByteW-1:0]  req_byte_value,
   input  logic                         req_first_byte,
   input  logic                         req_last_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_status,
   output logic [wavhp_pkg::WordW-1:0]  rsp_sample_rate,
   output logic [wavhp_pkg::WordW-1:0]  rsp_data_bytes
);
   import wavhp_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [CountW-1:0]   count_ff, count_in;
   logic [WordW-1:0]    id_ff, id_in;
   logic [WordW-1:0]    size_ff, size_in;
   logic [HalfW-1:0]    audio_ff, audio_in;
   logic [HalfW-1:0]    chan_ff, chan_in;
   logic [WordW-1:0]    rate_ff, rate_in;
   logic [HalfW-1:0]    bits_ff, bits_in;
   logic                seen_ff, seen_in;

   logic                out_valid_ff, out_valid_in;
   logic                out_status_ff, out_status_in;
   logic [WordW-1:0]    out_rate_ff, out_rate_in;
   logic [WordW-1:0]    out_size_ff, out_size_in;

   logic                accept;
   logic                verdict;
   logic                v_status;
   logic [WordW-1:0]    v_rate;
   logic [WordW-1:0]    v_size;
   phase_type           cur_phase;
   logic [CountW-1:0]   cur_count;
   logic [WordW-1:0]    cur_id;
   logic [WordW-1:0]    cur_size;
   logic [HalfW-1:0]    cur_audio;
   logic [HalfW-1:0]    cur_chan;
   logic [WordW-1:0]    cur_rate;
   logic [HalfW-1:0]    cur_bits;
   logic                cur_seen;
   logic [CountW-1:0]   skip_len;

   assign req_stall = out_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // first byte restarts from the reset state
   always_comb begin
      if (req_first_byte) begin
         cur_phase = PH_HEAD;
         cur_count = '0;
         cur_id    = '0;
         cur_size  = '0;
         cur_audio = '0;
         cur_chan  = '0;
         cur_rate  = '0;
         cur_bits  = '0;
         cur_seen  = 1'b0;
      end else begin
         cur_phase = phase_ff;
         cur_count = count_ff;
         cur_id    = id_ff;
         cur_size  = size_ff;
         cur_audio = audio_ff;
         cur_chan  = chan_ff;
         cur_rate  = rate_ff;
         cur_bits  = bits_ff;
         cur_seen  = seen_ff;
      end
   end

   always_comb begin
      phase_in = cur_phase;
      count_in = cur_count;
      id_in    = cur_id;
      size_in  = cur_size;
      audio_in = cur_audio;
      chan_in  = cur_chan;
      rate_in  = cur_rate;
      bits_in  = cur_bits;
      seen_in  = cur_seen;
      verdict  = 1'b0;
      v_status = StatusReject;
      v_rate   = '0;
      v_size   = '0;
      skip_len = '0;

      unique case (cur_phase)
         PH_HEAD: begin
            id_in = {cur_id[WordW-ByteW-1:0], req_byte_value};
            if (cur_count == CountW'(3) && id_in != TagRiff) begin
               verdict = 1'b1;
            end else if (cur_count >= CountW'(11)) begin
               if (id_in != TagWave) begin
                  verdict = 1'b1;
               end else begin
                  phase_in = PH_CHUNK;
                  count_in = '0;
               end
            end else begin
               count_in = cur_count + CountW'(1);
            end
         end
         PH_CHUNK: begin
            if (cur_count < CountW'(4)) begin
               id_in = {cur_id[WordW-ByteW-1:0], req_byte_value};
            end else begin
               size_in = {req_byte_value, cur_size[WordW-1:ByteW]};
            end
            if (cur_count >= CountW'(7)) begin
               if (id_in == TagFmt) begin
                  if (size_in < FmtMinSize) begin
                     verdict = 1'b1;
                  end else begin
                     phase_in = PH_FMT;
                     count_in = '0;
                  end
               end else if (id_in == TagData) begin
                  verdict = 1'b1;
                  if (cur_seen) begin
                     v_status = StatusAccept;
                     v_rate   = cur_rate;
                     v_size   = size_in;
                  end
               end else begin
                  skip_len = {1'b0, size_in} + {{(CountW-1){1'b0}}, size_in[0]};
                  count_in = skip_len;
                  phase_in = (skip_len == '0) ? PH_CHUNK : PH_SKIP;
               end
            end else begin
               count_in = cur_count + CountW'(1);
            end
         end
         PH_FMT: begin
            if (cur_count < CountW'(2)) begin
               audio_in = {req_byte_value, cur_audio[HalfW-1:ByteW]};
            end else if (cur_count < CountW'(4)) begin
               chan_in = {req_byte_value, cur_chan[HalfW-1:ByteW]};
            end else if (cur_count < CountW'(8)) begin
               rate_in = {req_byte_value, cur_rate[WordW-1:ByteW]};
            end else if (cur_count >= CountW'(14)) begin
               bits_in = {req_byte_value, cur_bits[HalfW-1:ByteW]};
            end
            if (cur_count >= CountW'(15)) begin
               if (audio_in != FmtPcm || chan_in != FmtChannels || bits_in != FmtBits) begin
                  verdict = 1'b1;
               end else begin
                  seen_in  = 1'b1;
                  skip_len = {1'b0, cur_size - FmtMinSize}
                           + {{(CountW-1){1'b0}}, cur_size[0]};
                  count_in = skip_len;
                  phase_in = (skip_len == '0) ? PH_CHUNK : PH_SKIP;
               end
            end else begin
               count_in = cur_count + CountW'(1);
            end
         end
         PH_SKIP: begin
            if (cur_count <= CountW'(1)) begin
               phase_in = PH_CHUNK;
               count_in = '0;
            end else begin
               count_in = cur_count - CountW'(1);
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      // early end of stream
      if (req_last_byte && !verdict && cur_phase != PH_DONE) begin
         verdict  = 1'b1;
         v_status = StatusReject;
         v_rate   = '0;
         v_size   = '0;
      end
      if (verdict) begin
         phase_in = PH_DONE;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff & rsp_stall;
      out_status_in = out_status_ff;
      out_rate_in   = out_rate_ff;
      out_size_in   = out_size_ff;
      if (accept && verdict) begin
         out_valid_in  = 1'b1;
         out_status_in = v_status;
         out_rate_in   = v_rate;
         out_size_in   = v_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEAD;
         count_ff     <= '0;
         id_ff        <= '0;
         size_ff      <= '0;
         audio_ff     <= '0;
         chan_ff      <= '0;
         rate_ff      <= '0;
         bits_ff      <= '0;
         seen_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            id_ff    <= id_in;
            size_ff  <= size_in;
            audio_ff <= audio_in;
            chan_ff  <= chan_in;
            rate_ff  <= rate_in;
            bits_ff  <= bits_in;
            seen_ff  <= seen_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_rate_ff   <= out_rate_in;
      out_size_ff   <= out_size_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_sample_rate = out_rate_ff;
   assign rsp_data_bytes  = out_size_ff;

endmodule

// File: verif/wav_header_parser_unit_tb.sv
`timescale 1ns / 1ps

module wav_header_parser_unit_tb;
   import wavhp_pkg::*;

   typedef struct packed {
      logic             status;
      logic [WordW-1:0] rate;
      logic [WordW-1:0] data_len;
   } verdict_type;

   class header_verdict_board_type;
      phase_type         phase;
      logic [CountW-1:0] count;
      logic [WordW-1:0]  id_reg;
      logic [WordW-1:0]  size_reg;
      logic [WordW-1:0]  rate_reg;
      logic [HalfW-1:0]  code_reg;
      logic [HalfW-1:0]  chan_reg;
      logic [HalfW-1:0]  bits_reg;
      logic              fmt_ok;
      logic              done;
      verdict_type       verdict_q[$];
      int unsigned       bytes_cnt;
      int unsigned       accept_cnt;
      int unsigned       reject_cnt;
      int unsigned       checked_cnt;
      int unsigned       bad_cnt;

      function new();
         restart();
      endfunction

      function void restart();
         phase    = PH_HEAD;
         count    = '0;
         id_reg   = '0;
         size_reg = '0;
         rate_reg = '0;
         code_reg = '0;
         chan_reg = '0;
         bits_reg = '0;
         fmt_ok   = 1'b0;
         done     = 1'b0;
      endfunction

      function void issue(logic st, logic [WordW-1:0] r, logic [WordW-1:0] n);
         verdict_type v;
         v.status   = st;
         v.rate     = r;
         v.data_len = n;
         verdict_q.push_back(v);
         done  = 1'b1;
         phase = PH_DONE;
         if (st == StatusAccept) accept_cnt++;
         else reject_cnt++;
      endfunction

      function void skip_to(logic [CountW-1:0] n);
         count = n;
         phase = (n == 0) ? PH_CHUNK : PH_SKIP;
      endfunction

      function void take_byte(logic [ByteW-1:0] b, logic is_first, logic is_last);
         logic [CountW-1:0] c;
         bytes_cnt++;
         if (is_first) restart();
         if (done) return;
         c = count;
         case (phase)
            PH_HEAD: begin
               id_reg = {id_reg[23:0], b};
               if (c == 3 && id_reg != TagRiff) begin
                  issue(StatusReject, '0, '0);
               end else if (c >= 11) begin
                  if (id_reg != TagWave) begin
                     issue(StatusReject, '0, '0);
                  end else begin
                     phase = PH_CHUNK;
                     count = '0;
                  end
               end else begin
                  count = c + 1;
               end
            end
            PH_CHUNK: begin
               if (c < 4) id_reg = {id_reg[23:0], b};
               else size_reg = {b, size_reg[31:8]};
               if (c >= 7) begin
                  if (id_reg == TagFmt) begin
                     if (size_reg < FmtMinSize) begin
                        issue(StatusReject, '0, '0);
                     end else begin
                        phase = PH_FMT;
                        count = '0;
                     end
                  end else if (id_reg == TagData) begin
                     if (!fmt_ok) issue(StatusReject, '0, '0);
                     else issue(StatusAccept, rate_reg, size_reg);
                  end else begin
                     skip_to({1'b0, size_reg} + size_reg[0]);
                  end
               end else begin
                  count = c + 1;
               end
            end
            PH_FMT: begin
               if (c < 2) code_reg = {b, code_reg[15:8]};
               else if (c < 4) chan_reg = {b, chan_reg[15:8]};
               else if (c < 8) rate_reg = {b, rate_reg[31:8]};
               else if (c >= 14) bits_reg = {b, bits_reg[15:8]};
               if (c >= 15) begin
                  if (code_reg != FmtPcm || chan_reg != FmtChannels || bits_reg != FmtBits) begin
                     issue(StatusReject, '0, '0);
                  end else begin
                     fmt_ok = 1'b1;
                     skip_to({1'b0, size_reg - FmtMinSize} + size_reg[0]);
                  end
               end else begin
                  count = c + 1;
               end
            end
            PH_SKIP: begin
               if (c <= 1) begin
                  phase = PH_CHUNK;
                  count = '0;
               end else begin
                  count = c - 1;
               end
            end
            default: ;
         endcase
         // end of stream without a verdict
         if (is_last && !done) issue(StatusReject, '0, '0);
      endfunction

      function void match_verdict(logic st, logic [WordW-1:0] r, logic [WordW-1:0] n);
         verdict_type v;
         if (verdict_q.size() == 0) begin
            bad_cnt++;
            if (bad_cnt <= 10)
               $display("unexpected verdict: status %0d rate %h size %h", st, r, n);
            return;
         end
         v = verdict_q.pop_front();
         checked_cnt++;
         if (st !== v.status || r !== v.rate || n !== v.data_len) begin
            bad_cnt++;
            if (bad_cnt <= 10) begin
               $display("verdict mismatch: expected status %0d rate %h size %h",
                        v.status, v.rate, v.data_len);
               $display("                  got status %0d rate %h size %h", st, r, n);
            end
         end
      endfunction
   endclass

   logic             clock;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic             req_stall;
   logic [ByteW-1:0] req_byte_value = '0;
   logic             req_first_byte = 1'b0;
   logic             req_last_byte  = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall      = 1'b0;
   logic             rsp_status;
   logic [WordW-1:0] rsp_sample_rate;
   logic [WordW-1:0] rsp_data_bytes;

   header_verdict_board_type sb = new();
   logic [ByteW-1:0]    file_q[$];
   int                  burst_left;
   int                  hold_ask;
   int                  hold_seen;
   int                  hold_left;
   int                  stall_mode;
   int                  mode_left;
   logic [7:0]          stall_tick = '0;

   wav_header_parser_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte_value  (req_byte_value),
      .req_first_byte  (req_first_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_sample_rate (rsp_sample_rate),
      .rsp_data_bytes  (rsp_data_bytes)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic void put_tag(logic [WordW-1:0] t);
      file_q.push_back(t[31:24]);
      file_q.push_back(t[23:16]);
      file_q.push_back(t[15:8]);
      file_q.push_back(t[7:0]);
   endfunction

   function automatic void put_le(logic [WordW-1:0] w, int n);
      int k;
      for (k = 0; k < n; k++) file_q.push_back(w[8*k +: 8]);
   endfunction

   function automatic void put_rand(int n);
      repeat (n) file_q.push_back(ByteW'($urandom));
   endfunction

   function automatic void put_head(logic [WordW-1:0] riff_len);
      put_tag(TagRiff);
      put_le(riff_len, 4);
      put_tag(TagWave);
   endfunction

   function automatic void put_chunk(logic [WordW-1:0] id, logic [WordW-1:0] len);
      put_tag(id);
      put_le(len, 4);
   endfunction

   // chunk header plus the 16 fixed body bytes
   function automatic void put_fmt(logic [WordW-1:0] len, logic [HalfW-1:0] code,
                                   logic [HalfW-1:0] chan, logic [WordW-1:0] rate,
                                   logic [HalfW-1:0] bits);
      put_chunk(TagFmt, len);
      put_le(WordW'(code), 2);
      put_le(WordW'(chan), 2);
      put_le(rate, 4);
      put_le($urandom, 4);
      put_le($urandom, 2);
      put_le(WordW'(bits), 2);
   endfunction

   function automatic void put_junk();
      logic [WordW-1:0] len;
      len = $urandom_range(0, 9);
      put_chunk($urandom, len);
      put_rand(len + len[0]);
   endfunction

   function automatic void make_wav(output int hdr_end);
      logic [WordW-1:0] len;
      logic [HalfW-1:0] code;
      logic [HalfW-1:0] chan;
      logic [HalfW-1:0] bits;
      put_head($urandom);
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(16, 21);
            put_fmt(len, FmtPcm, FmtChannels, $urandom, FmtBits);
            put_rand(len - 16 + len[0]);
         end else begin
            put_junk();
         end
      end
      code = ($urandom_range(0, 15) == 0) ? HalfW'($urandom) : FmtPcm;
      chan = ($urandom_range(0, 15) == 0) ? HalfW'($urandom) : FmtChannels;
      bits = ($urandom_range(0, 15) == 0) ? HalfW'($urandom) : FmtBits;
      len  = ($urandom_range(0, 2) == 0) ? $urandom_range(17, 24) : FmtMinSize;
      put_fmt(len, code, chan, $urandom, bits);
      put_rand(len - 16 + len[0]);
      if ($urandom_range(0, 3) == 0) put_junk();
      put_chunk(TagData, $urandom);
      hdr_end = file_q.size() - 1;
      put_rand($urandom_range(0, 4));
   endfunction

   task automatic send_byte(input logic [ByteW-1:0] b, input logic is_first, input logic is_last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_byte_value <= b;
      req_first_byte <= is_first;
      req_last_byte  <= is_last;
      do @(posedge clock); while (req_stall);
      sb.take_byte(b, is_first, is_last);
   endtask

   task automatic send_file(input logic mark_first, input int cut);
      int i;
      for (i = 0; i < file_q.size(); i++) send_byte(file_q[i], mark_first && i == 0, i == cut);
      file_q.delete();
   endtask

   task automatic drain_verdicts();
      if (sb.verdict_q.size() != 0) begin
         req_valid <= 1'b0;
         while (sb.verdict_q.size() != 0) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.match_verdict(rsp_status, rsp_sample_rate, rsp_data_bytes);
      stall_tick++;
      if (hold_seen != hold_ask) begin
         hold_seen = hold_ask;
         hold_left = 80;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= $urandom_range(0, 99) < 30;
            2: rsp_stall <= $urandom_range(0, 99) < 75;
            default: rsp_stall <= stall_tick[2:0] < 3;
         endcase
      end
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int k;
      int kind;
      int pick;
      int cut;
      int idx;
      int hdr_end;
      int streams;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // parser starts without a first byte mark
      put_tag(TagRiff ^ 32'h1);
      send_file(1'b0, -1);
      put_head(32'hFFFF_FFFF);
      file_q[11] ^= 8'h80;
      send_file(1'b1, -1);
      put_rand(1);
      send_file(1'b1, 0);
      // extreme rate and size, then trailing bytes ignored
      put_head('0);
      put_fmt(FmtMinSize, FmtPcm, FmtChannels, '1, FmtBits);
      put_chunk(TagData, '1);
      put_rand(3);
      send_file(1'b1, file_q.size() - 1);
      put_rand(5);
      send_file(1'b0, -1);
      // odd sizes with pad bytes, later fmt overrides
      put_head($urandom);
      put_fmt(32'd17, FmtPcm, FmtChannels, 32'd1, FmtBits);
      put_rand(2);
      put_chunk(32'h4C49_5354, 32'd3);
      put_rand(4);
      put_chunk(32'h4C49_5354, 32'd0);
      put_fmt(FmtMinSize, FmtPcm, FmtChannels, '0, FmtBits);
      put_chunk(TagData, '0);
      send_file(1'b1, -1);
      put_head('0);
      put_chunk(TagData, 32'd5);
      send_file(1'b1, -1);
      put_head('0);
      put_chunk(TagFmt, FmtMinSize - 1);
      send_file(1'b1, -1);
      for (k = 0; k < 3; k++) begin
         put_head($urandom);
         put_fmt(FmtMinSize, k == 0 ? 16'hFFFF : FmtPcm, k == 1 ? 16'h0001 : FmtChannels,
                 $urandom, k == 2 ? 16'h0008 : FmtBits);
         send_file(1'b1, -1);
      end
      // stream ends inside very long skips
      put_head('0);
      put_fmt('1, FmtPcm, FmtChannels, $urandom, FmtBits);
      put_rand(5);
      send_file(1'b1, file_q.size() - 1);
      put_head('0);
      put_chunk(32'h4A55_4E4B, '1);
      put_rand(3);
      send_file(1'b1, file_q.size() - 1);

      while (sb.bytes_cnt < 1450) begin
         if (streams % 16 == 5) begin
            // output held off while short rejected streams keep coming
            hold_ask++;
            repeat (6) begin
               put_tag($urandom);
               send_file(1'b1, -1);
            end
            drain_verdicts();
         end
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            make_wav(hdr_end);
            if ($urandom_range(0, 11) == 0) begin
               idx = $urandom_range(0, file_q.size() - 1);
               file_q[idx] ^= ByteW'($urandom_range(1, 255));
            end
            pick = $urandom_range(0, 9);
            cut  = (pick == 0) ? $urandom_range(0, file_q.size() - 1) :
                   (pick == 1) ? hdr_end : (pick == 2) ? file_q.size() - 1 : -1;
            send_file($urandom_range(0, 19) != 0, cut);
         end else if (kind < 70) begin
            put_head($urandom);
            put_chunk(TagFmt, $urandom_range(0, 15));
            put_rand($urandom_range(0, 16));
            send_file(1'b1, -1);
         end else if (kind < 80) begin
            put_head($urandom);
            if ($urandom_range(0, 1) == 0) put_junk();
            put_chunk(TagData, $urandom);
            put_rand($urandom_range(0, 4));
            send_file(1'b1, -1);
         end else if (kind < 88) begin
            put_head($urandom);
            idx = $urandom_range(0, 11);
            file_q[idx] ^= ByteW'($urandom_range(1, 255));
            send_file(1'b1, -1);
         end else begin
            repeat ($urandom_range(1, 12))
               send_byte(ByteW'($urandom), $urandom_range(0, 6) == 0, $urandom_range(0, 11) == 0);
         end
         if ($urandom_range(0, 11) == 0) drain_verdicts();
         streams++;
      end

      drain_verdicts();
      req_valid <= 1'b0;
      repeat (10) @(posedge clock);
      $display("run: %0d bytes in %0d random streams plus directed headers",
               sb.bytes_cnt, streams);
      $display("run: %0d accepted, %0d rejected, %0d compared, %0d mismatches",
               sb.accept_cnt, sb.reject_cnt, sb.checked_cnt, sb.bad_cnt);
      if (sb.bad_cnt == 0 && sb.verdict_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/wavhp_pkg.sv
rtl/wav_header_parser_unit.sv
verif/wav_header_parser_unit_tb.sv
